// ----- rtl/kat_pkg.sv -----
// Shared constants, request codes and controller/datapath command types
// for the keyed accumulator table. No dependencies.
`default_nettype none

package kat_pkg;

  // Table geometry
  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);

  // Field widths
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned KEY_STORE_W = KEY_BYTES * 8;
  localparam int unsigned AMT_W       = 16;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned REQ_W       = 2;

  // Request codes; the fourth code is ignored
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ERASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic req_load;   // capture the accepted request
    logic match_en;   // register the parallel key compare
    logic index_en;   // encode hit/free indexes, read the stored sum
    logic sum_upd;    // write the saturated sum at the hit entry
    logic entry_new;  // claim the free entry for a new key
    logic entry_clr;  // clear the valid mark of the hit entry
    logic out_load;   // load the result register
  } kat_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             hit;
    logic             full;
  } kat_sts_t;

endpackage

`default_nettype wire

// ----- rtl/kat_if.sv -----
// Request and response channel interfaces for the keyed accumulator table.
// Depends on kat_pkg for field widths.
`default_nettype none

interface kat_req_if;
  logic                             valid;
  logic                             ready;
  logic [kat_pkg::REQ_W-1:0]        req_type;
  logic [kat_pkg::KEY_W-1:0]        key;
  logic [kat_pkg::AMT_W-1:0]        amount;

  modport source (output valid, req_type, key, amount, input ready);
  modport sink   (input valid, req_type, key, amount, output ready);
endinterface

interface kat_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [kat_pkg::SUM_W-1:0]        sum_value;
  logic                             key_found;
  logic                             add_dropped;

  modport source (output valid, sum_value, key_found, add_dropped, input ready);
  modport sink   (input valid, sum_value, key_found, add_dropped, output ready);
endinterface

`default_nettype wire

// ----- rtl/kat_datapath.sv -----
// Datapath of the keyed accumulator table: key registers with parallel
// compare, valid marks, sum memory and result register. Uses kat_pkg.
`default_nettype none

module kat_datapath (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  kat_pkg::kat_cmd_t          cmd_i,
  output kat_pkg::kat_sts_t          sts_o,
  input  wire [kat_pkg::REQ_W-1:0]   req_type_i,
  input  wire [kat_pkg::KEY_W-1:0]   key_i,
  input  wire [kat_pkg::AMT_W-1:0]   amount_i,
  output logic [kat_pkg::SUM_W-1:0]  sum_value_o,
  output logic                       key_found_o,
  output logic                       add_dropped_o
);
  import kat_pkg::*;

  // Request registers
  logic [REQ_W-1:0]       req_type_q;
  logic [KEY_STORE_W-1:0] req_key_q;
  logic [AMT_W-1:0]       amount_q;

  // Table storage
  logic [KEY_STORE_W-1:0] entry_key_q [ENTRIES];
  logic [ENTRIES-1:0]     valid_q;
  logic [SUM_W-1:0]       sum_mem [ENTRIES];
  logic [SUM_W-1:0]       rd_sum_q;

  // Match and index registers
  logic [ENTRIES-1:0]     hit_vec_d, hit_vec_q;
  logic [IDX_W-1:0]       hit_idx_d, hit_idx_q;
  logic [IDX_W-1:0]       free_idx_d, free_idx_q;
  logic                   hit_q, full_q;

  // Update and result logic
  logic [SUM_W:0]         sum_ext;
  logic [SUM_W-1:0]       sum_sat;
  logic [IDX_W-1:0]       wr_addr;
  logic [SUM_W-1:0]       wr_data;
  logic                   is_query, is_drop;

  // Capture the request, dropping key bits above the stored key width
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_type_q <= req_type_i;
      req_key_q  <= key_i[KEY_STORE_W-1:0];
      amount_q   <= amount_i;
    end
  end

  // Compare the key against every valid entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec_d[i] = valid_q[i] && (entry_key_q[i] == req_key_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_vec_q <= '0;
    end else if (cmd_i.match_en) begin
      hit_vec_q <= hit_vec_d;
    end
  end

  // Encode the one-hot hit vector and find the lowest free entry
  always_comb begin
    hit_idx_d  = '0;
    free_idx_d = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec_q[i]) begin
        hit_idx_d = hit_idx_d | IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx_d = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      full_q <= 1'b0;
    end else if (cmd_i.index_en) begin
      hit_q  <= |hit_vec_q;
      full_q <= &valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.index_en) begin
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
    end
  end

  // Saturating add of the amount to the stored sum
  assign sum_ext = {1'b0, rd_sum_q} + (SUM_W + 1)'(amount_q);
  assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign wr_addr = cmd_i.sum_upd ? hit_idx_q : free_idx_q;
  assign wr_data = cmd_i.sum_upd ? sum_sat : SUM_W'(amount_q);

  // Sum memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_upd || cmd_i.entry_new) begin
      sum_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.index_en) begin
      rd_sum_q <= sum_mem[hit_idx_d];
    end
  end

  // Write the key of a newly claimed entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.entry_new) begin
      entry_key_q[free_idx_q] <= req_key_q;
    end
  end

  // Set or clear valid marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.entry_new) begin
      valid_q[free_idx_q] <= 1'b1;
    end else if (cmd_i.entry_clr) begin
      valid_q[hit_idx_q] <= 1'b0;
    end
  end

  // Result register
  assign is_query = (req_type_q == REQ_QUERY);
  assign is_drop  = (req_type_q == REQ_ADD) && !hit_q && full_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sum_value_o   <= (is_query && hit_q) ? rd_sum_q : '0;
      key_found_o   <= is_query && hit_q;
      add_dropped_o <= is_drop;
    end
  end

  assign sts_o.req_type = req_type_q;
  assign sts_o.hit      = hit_q;
  assign sts_o.full     = full_q;

  // Valid keys are unique, so at most one entry matches
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec_q))
    else $error("more than one entry matches the key");

  // A new entry is valid after the claim
  a_new_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.entry_new |=> valid_q[$past(free_idx_q)])
    else $error("claimed entry not marked valid");

  // An erased entry is free after the erase
  a_clr_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.entry_clr |=> !valid_q[$past(hit_idx_q)])
    else $error("erased entry still valid");

endmodule

`default_nettype wire

// ----- rtl/kat_ctrl.sv -----
// Controller of the keyed accumulator table: sequences match, index and
// update steps and owns the result valid flag. Uses kat_pkg.
`default_nettype none

module kat_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  wire                rsp_ready_i,
  input  kat_pkg::kat_sts_t  sts_i,
  output kat_pkg::kat_cmd_t  cmd_o
);
  import kat_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_INDEX  = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state_d, state_q;
  logic       out_valid_d, out_valid_q;
  logic       need_rsp, out_free;
  logic       is_add;

  assign is_add   = (sts_i.req_type == REQ_ADD);
  assign need_rsp = (sts_i.req_type == REQ_QUERY) || (is_add && !sts_i.hit && sts_i.full);
  assign out_free = !out_valid_q || rsp_ready_i;

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

  // Step through one request; hold in update while the result has no room
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.req_load = req_valid_i;
        if (req_valid_i) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match_en = 1'b1;
        state_d        = ST_INDEX;
      end
      ST_INDEX: begin
        cmd_o.index_en = 1'b1;
        state_d        = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!need_rsp || out_free) begin
          cmd_o.sum_upd   = is_add && sts_i.hit;
          cmd_o.entry_new = is_add && !sts_i.hit && !sts_i.full;
          cmd_o.entry_clr = (sts_i.req_type == REQ_ERASE) && sts_i.hit;
          cmd_o.out_load  = need_rsp;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted request moves straight to the compare step
  a_accept_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == ST_MATCH))
    else $error("accepted request did not start a compare");

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || rsp_ready_i))
    else $error("result register overwritten");

  // At most one table update per request step
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sum_upd, cmd_o.entry_new, cmd_o.entry_clr}))
    else $error("conflicting table updates");

endmodule

`default_nettype wire

// ----- rtl/keyed_accumulator_table.sv -----
// Keyed accumulator table: associative key/sum store with add, erase and
// query requests. Top level; uses kat_pkg, kat_if, kat_ctrl, kat_datapath.
//
// Channels: req_i carries req_type, key and amount; rsp_o carries
// sum_value, key_found and add_dropped. A transfer happens on a rising edge
// with valid and ready both high.
// A query gives one response; an add that finds the table full gives one
// response with add_dropped set; other requests give none.
// Each request steps through accept, parallel key compare over all
// entries, hit/free index encode with the sum memory read, then update.
// The response is valid the cycle after the update step, so the next request
// is taken at the same time the response is offered. The sequence of
// dependent compare, encode and read-modify-write on the sum memory means
// a new request is accepted only after the previous one leaves update.
// Reset clears all valid marks at once; no clearing pass is needed.
// If the receiver stalls, the response is held; a later request that needs
// a response waits in its update step until the held one is taken.
`default_nettype none

module keyed_accumulator_table (
  input  wire        clk_i,
  input  wire        rst_ni,
  kat_req_if.sink    req_i,
  kat_rsp_if.source  rsp_o
);
  import kat_pkg::*;

  kat_cmd_t cmd;
  kat_sts_t sts;

  kat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kat_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .key_i         (req_i.key),
    .amount_i      (req_i.amount),
    .sum_value_o   (rsp_o.sum_value),
    .key_found_o   (rsp_o.key_found),
    .add_dropped_o (rsp_o.add_dropped)
  );

endmodule

`default_nettype wire
